### rtl/text_terminal_cell_buffer_assert.svh
// Assertion macros for the terminal cell buffer
`ifndef TEXT_TERMINAL_CELL_BUFFER_ASSERT_SVH
`define TEXT_TERMINAL_CELL_BUFFER_ASSERT_SVH

`ifndef SYNTH
// condition must never hold
`define TTCB_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ttcb assertion failed");
// antecedent implies consequent in the next cycle
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttcb assertion failed");
`else
`define TTCB_ASSERT_NEVER(label, clk, rst, cond)
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/ttcb_pkg.sv
package ttcb_pkg;

   // geometry defaults
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;
   localparam int QUEUE_DEPTH     = 2;

   // register file
   localparam int CSR_DATA_W = 8;
   typedef enum logic [1:0] {
      CSR_COLUMNS   = 2'd0,
      CSR_ROWS      = 2'd1,
      CSR_TAB_WIDTH = 2'd2
   } csr_index_type;

   localparam logic [7:0] RESET_COLUMNS   = 8'd80;
   localparam logic [6:0] RESET_ROWS      = 7'd25;
   localparam logic [4:0] RESET_TAB_WIDTH = 5'd3;

   // opcodes
   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_NAV  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // character codes
   localparam logic [15:0] CODE_BS    = 16'd8;
   localparam logic [15:0] CODE_TAB   = 16'd9;
   localparam logic [15:0] CODE_LF    = 16'd10;
   localparam logic [15:0] CODE_CR    = 16'd13;
   localparam logic [15:0] CODE_ESC   = 16'd27;
   localparam logic [15:0] SPACE_CODE = 16'h0020;

   // navigation keys
   localparam logic [3:0] NAV_HOME   = 4'd0;
   localparam logic [3:0] NAV_END    = 4'd1;
   localparam logic [3:0] NAV_PGUP   = 4'd2;
   localparam logic [3:0] NAV_PGDN   = 4'd3;
   localparam logic [3:0] NAV_LEFT   = 4'd4;
   localparam logic [3:0] NAV_RIGHT  = 4'd5;
   localparam logic [3:0] NAV_UP     = 4'd6;
   localparam logic [3:0] NAV_DOWN   = 4'd7;
   localparam logic [3:0] NAV_DELETE = 4'd8;

   // classified work kinds
   typedef enum logic [3:0] {
      K_NONE,
      K_PRINT,
      K_BS,
      K_TAB,
      K_LF,
      K_CR,
      K_ESC,
      K_NAV,
      K_READ
   } ttcb_kind_type;

   typedef struct packed {
      ttcb_kind_type kind;
      logic [15:0]   code;
      logic [15:0]   reps;
      logic [3:0]    nav_key;
      logic [6:0]    rcol;
      logic [5:0]    rrow;
   } ttcb_job_type;

   typedef struct packed {
      logic         valid;
      ttcb_job_type job;
   } ttcb_q_status_type;

endpackage

### rtl/ttcb_front.sv
module ttcb_front (
   input  logic                  start,
   input  logic                  q_full,
   input  logic                  clearing,
   output logic                  busy,
   output logic                  push,
   output ttcb_pkg::ttcb_job_type push_job,
   input  logic [1:0]            req_opcode,
   input  logic [15:0]           req_char_code,
   input  logic [15:0]           req_repeat_count,
   input  logic [3:0]            req_nav_key,
   input  logic [6:0]            req_read_column,
   input  logic [5:0]            req_read_row
);
   import ttcb_pkg::*;

   ttcb_kind_type kind;

   // accept when queue has room and no clearing pass runs
   assign busy = q_full | clearing;
   assign push = start & ~busy;

   // classify the transaction
   always_comb begin
      kind = K_NONE;
      priority if (req_opcode == OP_CHAR) begin
         priority if (req_repeat_count == 16'd0) kind = K_NONE;
         else if (req_char_code == CODE_BS)      kind = K_BS;
         else if (req_char_code == CODE_TAB)     kind = K_TAB;
         else if (req_char_code == CODE_LF)      kind = K_LF;
         else if (req_char_code == CODE_CR)      kind = K_CR;
         else if (req_char_code == CODE_ESC)     kind = K_ESC;
         else                                    kind = K_PRINT;
      end else if (req_opcode == OP_NAV) begin
         kind = K_NAV;
      end else if (req_opcode == OP_READ) begin
         kind = K_READ;
      end else begin
         kind = K_NONE;
      end
   end

   always_comb begin
      push_job.kind    = kind;
      push_job.code    = req_char_code;
      push_job.reps    = req_repeat_count;
      push_job.nav_key = req_nav_key;
      push_job.rcol    = req_read_column;
      push_job.rrow    = req_read_row;
   end

endmodule

### rtl/ttcb_queue.sv
module ttcb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ttcb_pkg::ttcb_job_type      push_job,
   input  logic                        pop,
   output logic                        full,
   output ttcb_pkg::ttcb_q_status_type status
);
   import ttcb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   ttcb_job_type    entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & (count_ff != '0);
   assign status.valid = (count_ff != '0);
   assign status.job   = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/ttcb_back.sv
module ttcb_back #(
   parameter int MAX_COLUMNS = ttcb_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ttcb_pkg::DEF_MAX_ROWS,
   parameter int CNW         = $clog2(MAX_COLUMNS + 1),
   parameter int RNW         = $clog2(MAX_ROWS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CNW-1:0]              ucols,
   input  logic [RNW-1:0]              urows,
   input  logic [4:0]                  tabw,
   input  logic                        clr_req,
   input  ttcb_pkg::ttcb_q_status_type q_status,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        rsp_strobe,
   output logic [6:0]                  rsp_caret_column,
   output logic [5:0]                  rsp_caret_row,
   output logic [15:0]                 rsp_cell_value
);
   import ttcb_pkg::*;

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int PW    = (CW > 5) ? CW : 5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_TMOD,
      S_DEL,
      S_RDWAIT
   } state_type;

   logic [15:0]   store_ff [DEPTH];
   logic [15:0]   rd_data_ff;

   state_type     state_ff, state_in;
   ttcb_job_type  job_ff, job_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] wx_ff, wx_in;
   logic          rdv_ff, rdv_in;
   logic [CW-1:0] tph_ff, tph_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          esc_ff, esc_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [6:0]    rsp_col_ff, rsp_col_in;
   logic [5:0]    rsp_row_ff, rsp_row_in;
   logic [15:0]   rsp_val_ff, rsp_val_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;

   logic [CNW-1:0] col_p1, x_p1;
   logic [RNW-1:0] row_p1;
   logic           col_wrap, row_wrap;
   logic [CW-1:0]  adv_col;
   logic [RW-1:0]  adv_row, dn_row;
   logic [CW-1:0]  tph_next;
   logic           in_grid;

   assign clearing         = (state_ff == S_CLEAR);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_caret_column = rsp_col_ff;
   assign rsp_caret_row    = rsp_row_ff;
   assign rsp_cell_value   = rsp_val_ff;

   // caret advance with wrap
   always_comb begin
      col_p1   = CNW'(col_ff) + CNW'(1);
      row_p1   = RNW'(row_ff) + RNW'(1);
      x_p1     = CNW'(x_ff) + CNW'(1);
      col_wrap = (col_p1 >= ucols);
      row_wrap = (row_p1 >= urows);
      dn_row   = row_wrap ? '0 : RW'(row_p1);
      adv_col  = col_wrap ? '0 : CW'(col_p1);
      adv_row  = col_wrap ? dn_row : row_ff;
      // tab phase tracks column modulo tab width
      if (col_wrap || (PW'(tph_ff) + PW'(1) == PW'(tabw))) begin
         tph_next = '0;
      end else begin
         tph_next = tph_ff + CW'(1);
      end
      in_grid = ({2'b00, job_ff.rcol} < 9'(ucols)) && ({2'b00, job_ff.rrow} < 8'(urows));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      x_in          = x_ff;
      wx_in         = wx_ff;
      rdv_in        = rdv_ff;
      tph_in        = tph_ff;
      clr_addr_in   = clr_addr_ff;
      esc_in        = esc_ff;
      rsp_strobe_in = 1'b0;
      rsp_val_in    = '0;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = SPACE_CODE;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            col_in    = '0;
            row_in    = '0;
            if ((clr_addr_ff[CW-1:0] == '1) &&
                (RNW'(clr_addr_ff[AW-1:CW]) + RNW'(1) == urows)) begin
               state_in      = S_IDLE;
               rsp_strobe_in = esc_ff;
               esc_in        = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (q_status.valid) begin
               q_pop  = 1'b1;
               job_in = q_status.job;
               cnt_in = q_status.job.reps;
               if (q_status.job.kind == K_TAB) begin
                  tph_in   = col_ff;
                  state_in = S_TMOD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         // column modulo tab width by repeated subtraction
         S_TMOD: begin
            if (PW'(tph_ff) >= PW'(tabw)) begin
               tph_in = CW'(PW'(tph_ff) - PW'(tabw));
            end else begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (job_ff.kind)
               K_NONE: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               K_READ: begin
                  if (in_grid) begin
                     mem_re    = 1'b1;
                     mem_raddr = {RW'(job_ff.rrow), CW'(job_ff.rcol)};
                     state_in  = S_RDWAIT;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               K_NAV: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  unique case (job_ff.nav_key)
                     NAV_HOME:  col_in = '0;
                     NAV_END:   col_in = CW'(ucols - CNW'(1));
                     NAV_PGUP:  row_in = '0;
                     NAV_PGDN:  row_in = RW'(urows - RNW'(1));
                     NAV_LEFT:  if (col_ff != '0) col_in = col_ff - CW'(1);
                     NAV_RIGHT: if (col_p1 < ucols) col_in = CW'(col_p1);
                     NAV_UP:    if (row_ff != '0) row_in = row_ff - RW'(1);
                     NAV_DOWN:  if (row_p1 < urows) row_in = RW'(row_p1);
                     NAV_DELETE: begin
                        rsp_strobe_in = 1'b0;
                        x_in          = col_ff;
                        rdv_in        = 1'b0;
                        state_in      = S_DEL;
                     end
                     default: ;
                  endcase
               end
               K_PRINT, K_TAB: begin
                  mem_we    = 1'b1;
                  mem_waddr = {row_ff, col_ff};
                  mem_wdata = (job_ff.kind == K_TAB) ? SPACE_CODE : job_ff.code;
                  col_in    = adv_col;
                  row_in    = adv_row;
                  tph_in    = tph_next;
                  if ((job_ff.kind == K_PRINT) || (tph_next == '0)) begin
                     cnt_in = cnt_ff - 16'd1;
                     if (cnt_ff == 16'd1) begin
                        rsp_strobe_in = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
               end
               K_LF, K_CR: begin
                  if (job_ff.kind == K_CR) col_in = '0;
                  row_in = dn_row;
                  cnt_in = cnt_ff - 16'd1;
                  if (cnt_ff == 16'd1) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               K_BS: begin
                  if (col_ff == '0) begin
                     // nothing left to erase on this row
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     col_in   = col_ff - CW'(1);
                     x_in     = col_ff - CW'(1);
                     rdv_in   = 1'b0;
                     state_in = S_DEL;
                  end
               end
               K_ESC: begin
                  clr_addr_in = '0;
                  esc_in      = 1'b1;
                  state_in    = S_CLEAR;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end

         // row shift: read x+1 while writing the previous read to x
         S_DEL: begin
            if (rdv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = {row_ff, wx_ff};
               mem_wdata = rd_data_ff;
            end
            if (x_p1 < ucols) begin
               mem_re    = 1'b1;
               mem_raddr = {row_ff, CW'(x_p1)};
               wx_in     = x_ff;
               x_in      = CW'(x_p1);
               rdv_in    = 1'b1;
            end else begin
               rdv_in = 1'b0;
               if (!rdv_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = {row_ff, CW'(ucols - CNW'(1))};
                  mem_wdata = SPACE_CODE;
                  if ((job_ff.kind == K_BS) && (cnt_ff > 16'd1)) begin
                     cnt_in   = cnt_ff - 16'd1;
                     state_in = S_EXEC;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
            end
         end

         S_RDWAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_val_in    = rd_data_ff;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      // geometry change restarts the clearing pass
      if (clr_req) begin
         state_in      = S_CLEAR;
         clr_addr_in   = '0;
         esc_in        = 1'b0;
         col_in        = '0;
         row_in        = '0;
         rsp_strobe_in = 1'b0;
      end

      rsp_col_in = 7'(col_in);
      rsp_row_in = 6'(row_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         esc_ff        <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         rdv_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         esc_ff        <= esc_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rdv_ff        <= rdv_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      x_ff       <= x_in;
      wx_ff      <= wx_in;
      tph_ff     <= tph_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_val_ff <= rsp_val_in;
   end

   // cell memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

endmodule

### rtl/text_terminal_cell_buffer.sv
// Character-cell terminal buffer with a caret.
// Input: req_* fields are taken at a rising edge where start is high and
// busy is low. Opcode 0 runs a character action repeat_count times, opcode 1
// applies one navigation key, opcode 2 reads one cell.
// Output: every transaction yields one result on rsp_* for a single cycle,
// flagged by rsp_strobe, unless a geometry write cuts it off; the receiver cannot hold it off.
// Configuration: csr_we writes csr_wdata into register csr_index (0 columns,
// 1 rows, 2 tab width). Writing columns or rows clears the cells and homes
// the caret.
// Flow: a transaction enters a two-entry queue and is picked up by the
// executor when it is idle. A character action writes one cell or moves the
// caret one step at a time; a tab first reduces the caret column modulo the
// tab width by repeated subtraction; a delete or backspace shifts the rest
// of the row left one cell at a time; a read uses the registered memory read.
// Reset and geometry writes start a clearing pass over the rows in use;
// busy stays high during it. ESC runs the same pass before its result.
module text_terminal_cell_buffer #(
   parameter int MAX_COLUMNS = ttcb_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = ttcb_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [15:0]                     req_char_code,
   input  logic [15:0]                     req_repeat_count,
   input  logic [3:0]                      req_nav_key,
   input  logic [6:0]                      req_read_column,
   input  logic [5:0]                      req_read_row,
   output logic                            rsp_strobe,
   output logic [6:0]                      rsp_caret_column,
   output logic [5:0]                      rsp_caret_row,
   output logic [15:0]                     rsp_cell_value,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [ttcb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ttcb_pkg::*;

`include "text_terminal_cell_buffer_assert.svh"

   localparam int CNW = $clog2(MAX_COLUMNS + 1);
   localparam int RNW = $clog2(MAX_ROWS + 1);
   localparam int RST_UCOLS = (int'(RESET_COLUMNS) > MAX_COLUMNS) ? MAX_COLUMNS
                                                                  : int'(RESET_COLUMNS);
   localparam int RST_UROWS = (int'(RESET_ROWS) > MAX_ROWS) ? MAX_ROWS : int'(RESET_ROWS);

   logic [CNW-1:0]    ucols_ff, ucols_in;
   logic [RNW-1:0]    urows_ff, urows_in;
   logic [4:0]        tabw_ff, tabw_in;
   logic              clr_req_ff, clr_req_in;

   logic              q_push, q_full, q_pop, clearing, front_busy;
   logic              geom_wr;
   ttcb_job_type      push_job;
   ttcb_q_status_type q_status;

   // registers held clamped to their usable ranges
   always_comb begin
      ucols_in   = ucols_ff;
      urows_in   = urows_ff;
      tabw_in    = tabw_ff;
      clr_req_in = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS: begin
               if (csr_wdata == '0) begin
                  ucols_in = CNW'(1);
               end else if (int'(csr_wdata) > MAX_COLUMNS) begin
                  ucols_in = CNW'(MAX_COLUMNS);
               end else begin
                  ucols_in = CNW'(csr_wdata);
               end
               clr_req_in = 1'b1;
            end
            CSR_ROWS: begin
               if (csr_wdata[6:0] == '0) begin
                  urows_in = RNW'(1);
               end else if (int'(csr_wdata[6:0]) > MAX_ROWS) begin
                  urows_in = RNW'(MAX_ROWS);
               end else begin
                  urows_in = RNW'(csr_wdata[6:0]);
               end
               clr_req_in = 1'b1;
            end
            CSR_TAB_WIDTH: begin
               tabw_in = (csr_wdata[4:0] == '0) ? 5'd1 : csr_wdata[4:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ucols_ff   <= CNW'(RST_UCOLS);
         urows_ff   <= RNW'(RST_UROWS);
         tabw_ff    <= RESET_TAB_WIDTH;
         clr_req_ff <= 1'b0;
      end else begin
         ucols_ff   <= ucols_in;
         urows_ff   <= urows_in;
         tabw_ff    <= tabw_in;
         clr_req_ff <= clr_req_in;
      end
   end

   assign busy = front_busy | clr_req_ff;

   ttcb_front u_front (
      .start            (start),
      .q_full           (q_full),
      .clearing         (clearing),
      .busy             (front_busy),
      .push             (q_push),
      .push_job         (push_job),
      .req_opcode       (req_opcode),
      .req_char_code    (req_char_code),
      .req_repeat_count (req_repeat_count),
      .req_nav_key      (req_nav_key),
      .req_read_column  (req_read_column),
      .req_read_row     (req_read_row)
   );

   ttcb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push & ~clr_req_ff),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .status   (q_status)
   );

   ttcb_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .CNW         (CNW),
      .RNW         (RNW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .ucols            (ucols_ff),
      .urows            (urows_ff),
      .tabw             (tabw_ff),
      .clr_req          (clr_req_ff),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_strobe       (rsp_strobe),
      .rsp_caret_column (rsp_caret_column),
      .rsp_caret_row    (rsp_caret_row),
      .rsp_cell_value   (rsp_cell_value)
   );

   // checks
   assign geom_wr = csr_we && (csr_index == CSR_COLUMNS || csr_index == CSR_ROWS);

   `TTCB_ASSERT_NEVER(a_no_overflow, clock, reset, q_push && q_full)
   `TTCB_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_strobe, !rsp_strobe)
   `TTCB_ASSERT_NEXT(a_geom_busy, clock, reset, geom_wr, busy)

endmodule

### verif/ttcb_checker.sv
// Watches the request, result and register ports of the terminal cell buffer,
// keeps its own copy of the cells and the caret, and checks every result.
module ttcb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_char_code,
   input  logic [15:0] req_repeat_count,
   input  logic [3:0]  req_nav_key,
   input  logic [6:0]  req_read_column,
   input  logic [5:0]  req_read_row,
   input  logic        rsp_strobe,
   input  logic [6:0]  rsp_caret_column,
   input  logic [5:0]  rsp_caret_row,
   input  logic [15:0] rsp_cell_value,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttcb_pkg::*;

   localparam int NCOLS = DEF_MAX_COLUMNS;
   localparam int NROWS = DEF_MAX_ROWS;

   typedef struct {
      logic [6:0]  caret_col;
      logic [5:0]  caret_row;
      logic [15:0] cell_val;
   } caret_result_type;

   logic [15:0]      screen [0:NCOLS*NROWS-1];
   int               caret_x, caret_y;
   int               reg_cols, reg_rows, reg_tab;
   caret_result_type expected_results [$];

   assign outstanding = expected_results.size();

   function automatic int cols_in_use();
      if (reg_cols < 1) return 1;
      if (reg_cols > NCOLS) return NCOLS;
      return reg_cols;
   endfunction

   function automatic int rows_in_use();
      if (reg_rows < 1) return 1;
      if (reg_rows > NROWS) return NROWS;
      return reg_rows;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic blank_screen();
      for (int i = 0; i < NCOLS*NROWS; i++) screen[i] = SPACE_CODE;
      caret_x = 0;
      caret_y = 0;
   endtask

   task automatic line_down();
      caret_y++;
      if (caret_y >= rows_in_use()) caret_y = 0;
   endtask

   task automatic write_cell(input logic [15:0] code);
      screen[caret_y*NCOLS + caret_x] = code;
      caret_x++;
      if (caret_x >= cols_in_use()) begin
         caret_x = 0;
         line_down();
      end
   endtask

   // pull the rest of the row left, blank the last column
   task automatic close_gap();
      int c;
      c = cols_in_use();
      for (int x = caret_x; x + 1 < c; x++)
         screen[caret_y*NCOLS + x] = screen[caret_y*NCOLS + x + 1];
      screen[caret_y*NCOLS + c - 1] = SPACE_CODE;
   endtask

   task automatic type_char(input logic [15:0] code);
      int tw;
      case (code)
         CODE_BS: begin
            if (caret_x > 0) begin
               caret_x--;
               close_gap();
            end
         end
         CODE_TAB: begin
            tw = (reg_tab == 0) ? 1 : reg_tab;
            do write_cell(SPACE_CODE); while (caret_x % tw != 0);
         end
         CODE_LF: line_down();
         CODE_CR: begin
            caret_x = 0;
            line_down();
         end
         CODE_ESC: blank_screen();
         default: write_cell(code);
      endcase
   endtask

   task automatic press_key(input logic [3:0] key);
      case (key)
         NAV_HOME:   caret_x = 0;
         NAV_END:    caret_x = cols_in_use() - 1;
         NAV_PGUP:   caret_y = 0;
         NAV_PGDN:   caret_y = rows_in_use() - 1;
         NAV_LEFT:   if (caret_x > 0) caret_x--;
         NAV_RIGHT:  if (caret_x + 1 < cols_in_use()) caret_x++;
         NAV_UP:     if (caret_y > 0) caret_y--;
         NAV_DOWN:   if (caret_y + 1 < rows_in_use()) caret_y++;
         NAV_DELETE: close_gap();
         default: ;
      endcase
   endtask

   task automatic predict_transaction();
      caret_result_type r;
      r.cell_val = '0;
      if (req_opcode == OP_CHAR) begin
         for (int i = 0; i < req_repeat_count; i++) type_char(req_char_code);
      end else if (req_opcode == OP_NAV) begin
         press_key(req_nav_key);
      end else if (req_opcode == OP_READ) begin
         if (req_read_column < cols_in_use() && req_read_row < rows_in_use())
            r.cell_val = screen[req_read_row*NCOLS + req_read_column];
      end
      r.caret_col = caret_x[6:0];
      r.caret_row = caret_y[5:0];
      expected_results.push_back(r);
   endtask

   initial begin
      fail_count = 0;
      reg_cols = RESET_COLUMNS;
      reg_rows = RESET_ROWS;
      reg_tab  = RESET_TAB_WIDTH;
      blank_screen();
   end

   always @(posedge clock) begin
      caret_result_type e;
      if (reset) begin
         reg_cols = RESET_COLUMNS;
         reg_rows = RESET_ROWS;
         reg_tab  = RESET_TAB_WIDTH;
         blank_screen();
         expected_results.delete();
      end else begin
         // compare before queuing this edge's transaction
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = expected_results.pop_front();
               if (rsp_caret_column !== e.caret_col)
                  report_mismatch($sformatf("caret_column %0d, expected %0d",
                                            rsp_caret_column, e.caret_col));
               if (rsp_caret_row !== e.caret_row)
                  report_mismatch($sformatf("caret_row %0d, expected %0d",
                                            rsp_caret_row, e.caret_row));
               if (rsp_cell_value !== e.cell_val)
                  report_mismatch($sformatf("cell_value %h, expected %h",
                                            rsp_cell_value, e.cell_val));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMNS: begin
                  reg_cols = csr_wdata;
                  blank_screen();
               end
               CSR_ROWS: begin
                  reg_rows = csr_wdata[6:0];
                  blank_screen();
               end
               CSR_TAB_WIDTH: reg_tab = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_transaction();
      end
   end

endmodule

### verif/tb.sv
module tb;
   import ttcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [15:0] req_char_code;
   logic [15:0] req_repeat_count;
   logic [3:0]  req_nav_key;
   logic [6:0]  req_read_column;
   logic [5:0]  req_read_row;
   logic        rsp_strobe;
   logic [6:0]  rsp_caret_column;
   logic [5:0]  rsp_caret_row;
   logic [15:0] rsp_cell_value;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   int          fail_count;
   int          outstanding;
   int          cycle_count;
   int          used_cols, used_rows;

   text_terminal_cell_buffer u_top (.*);

   ttcb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_terminal_cell_buffer verification failed");
         $finish;
      end
   end

   // one transaction: fields and start go out now, held until taken
   task automatic send(input logic [1:0] op, input logic [15:0] code,
                       input logic [15:0] reps, input logic [3:0] key,
                       input logic [6:0] rcol, input logic [5:0] rrow);
      start            <= 1'b1;
      req_opcode       <= op;
      req_char_code    <= code;
      req_repeat_count <= reps;
      req_nav_key      <= key;
      req_read_column  <= rcol;
      req_read_row     <= rrow;
      do @(posedge clock); while (busy);
   endtask

   // sender gaps: mostly none, some short, a few long
   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drain outstanding results, then reprogram geometry and tab stops
   task automatic set_geometry(input logic [7:0] c, input logic [6:0] r,
                               input logic [4:0] t);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_reg(CSR_COLUMNS, c);
      write_reg(CSR_ROWS, {1'b0, r});
      write_reg(CSR_TAB_WIDTH, {3'b0, t});
      used_cols = (c < 1) ? 1 : (c > 128 ? 128 : c);
      used_rows = (r < 1) ? 1 : (r > 64 ? 64 : r);
   endtask

   task automatic random_transaction();
      int          sel, k;
      logic [15:0] code, reps;
      sel  = $urandom_range(0, 99);
      reps = 16'($urandom_range(1, 3));
      k    = $urandom_range(0, 99);
      if (k < 12) reps = 0;
      else if (k < 24) reps = 16'($urandom_range(4, 40));
      if (sel < 40) begin
         k = $urandom_range(0, 99);
         if (k < 8) code = CODE_BS;
         else if (k < 16) code = CODE_TAB;
         else if (k < 22) code = CODE_LF;
         else if (k < 28) code = CODE_CR;
         else if (k < 30) begin
            code = CODE_ESC;
            reps = 16'($urandom_range(0, 2));
         end else if (k < 85) code = 16'($urandom_range(33, 126));
         else code = 16'($urandom);
         if (code == CODE_ESC) reps = (reps > 2) ? 16'd1 : reps;
         send(OP_CHAR, code, reps, 4'($urandom), 7'($urandom), 6'($urandom));
      end else if (sel < 65) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         send(OP_NAV, 16'($urandom), 16'($urandom), 4'(k), 7'($urandom), 6'($urandom));
      end else if (sel < 95) begin
         if ($urandom_range(0, 4) == 0)
            send(OP_READ, 16'($urandom), 16'($urandom), 4'($urandom),
                 7'($urandom), 6'($urandom));
         else
            send(OP_READ, 16'($urandom), 16'($urandom), 4'($urandom),
                 7'($urandom_range(0, used_cols - 1)),
                 6'($urandom_range(0, used_rows - 1)));
      end else begin
         send(OP_UNKNOWN, 16'($urandom), 16'($urandom), 4'($urandom), 7'($urandom),
              6'($urandom));
      end
   endtask

   initial begin
      int rounds;
      start            = 1'b0;
      req_opcode       = OP_CHAR;
      req_char_code    = '0;
      req_repeat_count = '0;
      req_nav_key      = '0;
      req_read_column  = '0;
      req_read_row     = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_COLUMNS;
      csr_wdata        = '0;
      used_cols        = RESET_COLUMNS;
      used_rows        = RESET_ROWS;
      reset            = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, each action and key, corner cases
      send(OP_READ, 16'h0, 16'h0, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, CODE_BS, 16'd1, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, 16'hFFFF, 16'd1, 4'hF, 7'h7F, 6'h3F);
      send(OP_CHAR, 16'h0041, 16'd0, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, 16'h0041, 16'hFFFF, 4'h0, 7'd0, 6'd0);
      send(OP_READ, 16'hFFFF, 16'hFFFF, 4'hF, 7'd5, 6'd3);
      send(OP_READ, 16'h0, 16'h0, 4'h0, 7'h7F, 6'h3F);
      send(OP_CHAR, CODE_TAB, 16'd2, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, CODE_LF, 16'd1, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, CODE_CR, 16'd30, 4'h0, 7'd0, 6'd0);
      send(OP_CHAR, CODE_BS, 16'd3, 4'h0, 7'd0, 6'd0);
      for (int k = 0; k <= 8; k++)
         send(OP_NAV, 16'h0, 16'hFFFF, 4'(k), 7'd0, 6'd0);
      send(OP_NAV, 16'h0, 16'h0, 4'hF, 7'd0, 6'd0);
      send(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 4'hF, 7'h7F, 6'h3F);
      send(OP_CHAR, CODE_ESC, 16'd1, 4'h0, 7'd0, 6'd0);
      send(OP_READ, 16'h0, 16'h0, 4'h0, 7'd0, 6'd0);

      // random phases across several geometries, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_geometry(8'd80, 7'd25, 5'd3);
            1: set_geometry(8'd1, 7'd1, 5'd0);
            2: set_geometry(8'd128, 7'd64, 5'd16);
            3: set_geometry(8'd0, 7'd0, 5'd1);
            4: set_geometry(8'd255, 7'd127, 5'd31);
            5: set_geometry(8'd8, 7'd4, 5'd5);
            default: set_geometry(8'd13, 7'd3, 5'd4);
         endcase
         rounds = 280;
         for (int i = 0; i < rounds; i++) begin
            random_transaction();
            idle_gap();
         end
      end
      start <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("text_terminal_cell_buffer verification clean");
      else
         $display("text_terminal_cell_buffer verification failed");
      $finish;
   end

endmodule
